// ----- hdl/ddfp_pkg.sv -----
// Shared types, constants and helper functions for the delimited decimal field parser.
// Has no dependencies; every other file in the block imports it.
package ddfp_pkg;

  localparam int unsigned FIELD_COUNT  = 21;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned MAG_W        = 32;
  localparam int unsigned TMO_W        = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = 1;
  localparam int unsigned QCNT_W       = 2;

  localparam logic [IDX_W-1:0] MAX_INDEX  = 5'd31;
  localparam logic [IDX_W-1:0] FIELD_MODE = 5'd1;
  localparam logic [MAG_W-1:0] MAG_LIMIT  = 32'h8000_0000;

  localparam logic [FIELD_COUNT-1:0] MASK_RESET    = 21'h1F_FFFF;
  localparam logic [TMO_W-1:0]       TIMEOUT_RESET = 16'd200;

  localparam logic [MAG_W-1:0] RECIP_TEN      = 32'd3435973837;
  localparam int unsigned      SHIFT_TEN      = 35;
  localparam logic [MAG_W-1:0] RECIP_THOUSAND = 32'd274877907;
  localparam int unsigned      SHIFT_THOUSAND = 38;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    SC_ONE,
    SC_TEN,
    SC_THOUSAND
  } scale_e;

  typedef enum logic [1:0] {
    MC_CHARGING,
    MC_DISCHARGING,
    MC_WAITING,
    MC_UNKNOWN
  } mode_e;

  typedef enum logic {
    REG_FIELD_MASK   = 1'b0,
    REG_IDLE_TIMEOUT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             neg;
    logic [MAG_W-1:0] mag;
    scale_e           scale;
    mode_e            mode;
  } field_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic scale_e field_scale(logic [IDX_W-1:0] idx);
    scale_e sc;
    case (idx)
      5'd0, 5'd1, 5'd3, 5'd4: sc = SC_ONE;
      5'd9, 5'd10:            sc = SC_TEN;
      default:                sc = SC_THOUSAND;
    endcase
    return sc;
  endfunction

endpackage

// ----- hdl/delimited_decimal_field_parser_top.sv -----
// Delimited decimal field parser top level: register port, front end, queue and back end.
// One word (byte or millisecond tick) is accepted per cycle while the queue has space.
// A result passes through the queue, the product register and the output register after its delimiter word is accepted.
// Sustained rate is one result per cycle while out_ready_i stays high.
// Reset returns the field index, parse state and idle timer to zero and the registers to defaults.
// Depends on ddfp_pkg, ddfp_front, ddfp_queue and ddfp_back.
module delimited_decimal_field_parser_top
  import ddfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [4:0]         field_number_o,
  output logic signed [31:0] scaled_value_o,
  output logic [1:0]         mode_class_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [FIELD_COUNT-1:0] mask_q;
  logic [TMO_W-1:0]       timeout_q;
  logic                   cfg_write;
  reg_e                   cfg_reg;

  logic        push;
  field_rec_t  front_rec;
  field_rec_t  queue_rec;
  logic        pop;
  queue_stat_t q_stat;

  assign pready    = 1'b1;
  assign cfg_reg   = reg_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_reg)
      REG_FIELD_MASK:   prdata = 32'(mask_q);
      REG_IDLE_TIMEOUT: prdata = 32'(timeout_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= MASK_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg)
        REG_FIELD_MASK:   mask_q    <= pwdata[FIELD_COUNT-1:0];
        REG_IDLE_TIMEOUT: timeout_q <= pwdata[TMO_W-1:0];
        default:          mask_q    <= mask_q;
      endcase
    end
  end

  ddfp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .rx_byte_i      (rx_byte_i),
    .field_mask_i   (mask_q),
    .idle_timeout_i (timeout_q),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .rec_o          (front_rec)
  );

  ddfp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (front_rec),
    .pop_i  (pop),
    .rec_o  (queue_rec),
    .stat_o (q_stat)
  );

  ddfp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .rec_i          (queue_rec),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .field_number_o (field_number_o),
    .scaled_value_o (scaled_value_o),
    .mode_class_o   (mode_class_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("Field record pushed into a full queue.");

  a_tick_never_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_TICK) |-> !push)
    else $error("A tick word produced a field record.");

  a_field_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (field_number_o < 5'(FIELD_COUNT)))
    else $error("Result word carries a field number beyond the field count.");

  a_mode_only_field_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && field_number_o != FIELD_MODE) |-> (mode_class_o == MC_UNKNOWN))
    else $error("Mode class set on a field other than the mode field.");

endmodule

// ----- hdl/ddfp_front.sv -----
// Front end of the parser: accepts words, tracks the field parse and the idle timer.
// Emits one field record per completed, enabled field into the queue. Uses ddfp_pkg.
module ddfp_front
  import ddfp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   command_i,
  input  logic [7:0]             rx_byte_i,
  input  logic [FIELD_COUNT-1:0] field_mask_i,
  input  logic [TMO_W-1:0]       idle_timeout_i,
  input  queue_stat_t            q_stat_i,
  output logic                   push_o,
  output field_rec_t             rec_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [MAG_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  phase_e           phase_q, phase_d;
  logic [TMO_W-1:0] ticks_q, ticks_d;

  logic             accept;
  logic             is_byte, is_dollar, is_eol, is_semi, is_delim;
  logic             is_blank, is_sign, is_digit;
  logic             active;
  logic [3:0]       digit;
  logic [MAG_W+3:0] acc_x10;
  logic [MAG_W-1:0] acc_sat;
  logic [TMO_W-1:0] ticks_inc;
  logic [31:0]      mask_ext;
  logic             field_on;
  mode_e            mode;

  assign in_ready_o = ~q_stat_i.full;
  assign accept     = in_valid_i & ~q_stat_i.full;

  always_comb begin
    is_byte   = (cmd_e'(command_i) == CMD_BYTE);
    is_dollar = (rx_byte_i == CH_DOLLAR);
    is_eol    = (rx_byte_i == CH_CR) || (rx_byte_i == CH_LF);
    is_semi   = (rx_byte_i == CH_SEMI);
    is_delim  = is_eol || is_semi;
    is_blank  = (rx_byte_i == CH_SPACE) || (rx_byte_i == CH_TAB) ||
                (rx_byte_i == CH_VT) || (rx_byte_i == CH_FF);
    is_sign   = (rx_byte_i == CH_PLUS) || (rx_byte_i == CH_MINUS);
    is_digit  = (rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE);
    digit     = 4'(rx_byte_i - CH_ZERO);
    active    = accept && is_byte && !is_dollar;
  end

  always_comb begin
    acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {{MAG_W{1'b0}}, digit};
    acc_sat = (acc_x10 > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : acc_x10[MAG_W-1:0];
  end

  // Next parse phase.
  always_comb begin
    phase_d = phase_q;
    if (active) begin
      if (is_delim) begin
        phase_d = PH_LEAD;
      end else begin
        case (phase_q)
          PH_LEAD: begin
            if (is_blank) begin
              phase_d = PH_LEAD;
            end else if (is_sign) begin
              phase_d = PH_SIGN;
            end else if (is_digit) begin
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_DONE;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            phase_d = is_digit ? PH_DIGITS : PH_DONE;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  // Accumulator, field index and idle timer.
  always_comb begin
    acc_d     = acc_q;
    neg_d     = neg_q;
    idx_d     = idx_q;
    ticks_d   = ticks_q;
    ticks_inc = (ticks_q == {TMO_W{1'b1}}) ? ticks_q : ticks_q + 1'b1;
    if (accept && !is_byte) begin
      ticks_d = ticks_inc;
      if (idx_q != '0 && ticks_inc >= idle_timeout_i) begin
        idx_d = '0;
      end
    end else if (accept) begin
      ticks_d = '0;
    end
    if (active) begin
      if (is_delim) begin
        acc_d = '0;
        neg_d = 1'b0;
        if (is_eol) begin
          idx_d = '0;
        end else if (idx_q != MAX_INDEX) begin
          idx_d = idx_q + 1'b1;
        end
      end else if (phase_q != PH_DONE && is_digit) begin
        acc_d = acc_sat;
      end else if (phase_q == PH_LEAD && is_sign) begin
        neg_d = (rx_byte_i == CH_MINUS);
      end
    end
  end

  // Completed-field record.
  always_comb begin
    mask_ext = 32'(field_mask_i);
    field_on = (idx_q < IDX_W'(FIELD_COUNT)) && mask_ext[idx_q];
    push_o   = active && is_delim && field_on;
    mode     = MC_UNKNOWN;
    if (idx_q == FIELD_MODE && !neg_q) begin
      case (acc_q)
        32'd1:   mode = MC_CHARGING;
        32'd2:   mode = MC_DISCHARGING;
        32'd4:   mode = MC_WAITING;
        default: mode = MC_UNKNOWN;
      endcase
    end
    rec_o.idx   = idx_q;
    rec_o.neg   = neg_q;
    rec_o.mag   = (!neg_q && acc_q == MAG_LIMIT) ? MAG_LIMIT - 1'b1 : acc_q;
    rec_o.scale = field_scale(idx_q);
    rec_o.mode  = mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      phase_q <= PH_LEAD;
      ticks_q <= '0;
    end else begin
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      phase_q <= phase_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

// ----- hdl/ddfp_queue.sv -----
// Short queue of field records between the parser front end and the scaling back end.
// Uses ddfp_pkg for the record type and depth constants.
module ddfp_queue
  import ddfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  field_rec_t  rec_i,
  input  logic        pop_i,
  output field_rec_t  rec_o,
  output queue_stat_t stat_o
);

  field_rec_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
    stat_o.empty = (cnt_q == '0);
    rec_o        = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- hdl/ddfp_back.sv -----
// Back end: scales each field record by reciprocal multiplication and drives the result word.
// Two registered stages, product then quotient and sign. Uses ddfp_pkg.
module ddfp_back
  import ddfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  queue_stat_t       q_stat_i,
  input  field_rec_t        rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IDX_W-1:0]  field_number_o,
  output logic signed [31:0] scaled_value_o,
  output logic [1:0]        mode_class_o
);

  logic             s1_valid_q;
  logic [63:0]      s1_prod_q, s1_prod_d;
  field_rec_t       s1_rec_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [31:0]      out_value_q, out_value_d;
  mode_e            out_mode_q;

  logic             out_adv;
  logic             s1_ready;
  logic [MAG_W-1:0] recip;
  logic [63:0]      shifted_ten, shifted_thousand;
  logic [MAG_W-1:0] quot;

  always_comb begin
    out_adv  = !out_valid_q || out_ready_i;
    s1_ready = !s1_valid_q || out_adv;
    pop_o    = !q_stat_i.empty && s1_ready;
    recip    = (rec_i.scale == SC_TEN) ? RECIP_TEN : RECIP_THOUSAND;
    s1_prod_d = 64'(rec_i.mag) * 64'(recip);
  end

  always_comb begin
    shifted_ten      = s1_prod_q >> SHIFT_TEN;
    shifted_thousand = s1_prod_q >> SHIFT_THOUSAND;
    case (s1_rec_q.scale)
      SC_ONE:      quot = s1_rec_q.mag;
      SC_TEN:      quot = shifted_ten[MAG_W-1:0];
      SC_THOUSAND: quot = shifted_thousand[MAG_W-1:0];
      default:     quot = s1_rec_q.mag;
    endcase
    out_value_d = s1_rec_q.neg ? (~quot + 1'b1) : quot;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_prod_q <= s1_prod_d;
      s1_rec_q  <= rec_i;
    end
    if (s1_valid_q && out_adv) begin
      out_idx_q   <= s1_rec_q.idx;
      out_value_q <= out_value_d;
      out_mode_q  <= s1_rec_q.mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= pop_o;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign field_number_o = out_idx_q;
  assign scaled_value_o = signed'(out_value_q);
  assign mode_class_o   = out_mode_q;

endmodule
